/* design/mmbcs_pkg.sv */
package mmbcs_pkg;

  localparam int AddrDefW  = 20;
  localparam int AddrExtW  = 24;
  localparam int QueueDepth = 4;

  localparam logic [1:0] OpMemRd = 2'd0;
  localparam logic [1:0] OpMemWr = 2'd1;
  localparam logic [1:0] OpIoRd  = 2'd2;
  localparam logic [1:0] OpIoWr  = 2'd3;

  localparam logic [2:0] StIoRd    = 3'd1;
  localparam logic [2:0] StIoWr    = 3'd2;
  localparam logic [2:0] StMemRd   = 3'd5;
  localparam logic [2:0] StMemWr   = 3'd6;
  localparam logic [2:0] StPassive = 3'd7;

  typedef struct packed {
    logic        busy;
    logic [15:0] read_value;
    logic        done;
    logic [2:0]  status_code;
    logic [11:0] high_address;
    logic        ad_enable;
    logic [7:0]  ad_value;
  } result_t;

  function automatic logic [2:0] op_status(input logic [1:0] op);
    logic [2:0] st;
    unique case (op)
      OpMemRd: st = StMemRd;
      OpMemWr: st = StMemWr;
      OpIoRd:  st = StIoRd;
      default: st = StIoWr;
    endcase
    return st;
  endfunction

endpackage

/* design/minimum_mode_bus_cycle_sequencer_top.sv */
// Minimum-mode bus cycle sequencer for an 8-bit multiplexed address/data bus.
// Input beat (in_tdata) is one bus clock period: start request, operation,
// word flag, address, write data, READY level and AD0-AD7 levels.
// Output beat (out_tdata) is the pin state for that period: AD value and
// enable, A8-A19, status S2S1S0, assembled read data and busy; out_tlast
// marks the final T4 of a transfer.
// Every input beat gives exactly one output beat, in order.
// An output beat is registered: it passes through a four-entry result queue
// and is shown on out_tdata once the beats queued ahead of it have been taken.
// Throughput: one beat per cycle while the queue is not full; the sequencer
// state advances once per accepted input beat, so the bus timing follows the
// beats, not the clock. When the receiver stalls, the queue fills; once it
// holds four beats, in_tready drops until out_tready takes a beat.
// Reset (rst_n low, synchronous) returns the sequencer to idle with AD
// floating, A8-A19 zero and the queue empty.
module minimum_mode_bus_cycle_sequencer_top #(
  parameter int ADDRESS_WIDTH = mmbcs_pkg::AddrDefW
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] start_req, [2:1] operation, [3] word, [23:4] address,
  // [39:24] write_data, [40] ready_req, [48:41] bus_data_in, [55:49] zero
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] ad_value, [8] ad_enable, [20:9] high_address, [23:21] status_code,
  // [39:24] read_value, [40] busy_res, [47:41] zero
  output logic [47:0] out_tdata,
  output logic        out_tlast
);

  logic               q_full;
  logic               step;
  mmbcs_pkg::result_t front_res;
  mmbcs_pkg::result_t back_res;

  assign in_tready = !q_full;
  assign step      = in_tvalid && in_tready;

  mmbcs_front #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .start_req  (in_tdata[0]),
    .operation  (in_tdata[2:1]),
    .word       (in_tdata[3]),
    .address    (in_tdata[23:4]),
    .write_data (in_tdata[39:24]),
    .ready_req  (in_tdata[40]),
    .bus_data_in(in_tdata[48:41]),
    .res        (front_res)
  );

  mmbcs_queue #(
    .DEPTH(mmbcs_pkg::QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (step),
    .push_data(front_res),
    .full     (q_full),
    .pop_valid(out_tvalid),
    .pop_ready(out_tready),
    .pop_data (back_res)
  );

  assign out_tdata = {7'd0, back_res.busy, back_res.read_value, back_res.status_code,
                      back_res.high_address, back_res.ad_enable, back_res.ad_value};
  assign out_tlast = back_res.done;

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (step && front_res.done) |-> front_res.busy)
    else $error("transfer done outside a busy period");

  a_passive_float: assert property (@(posedge clk) disable iff (!rst_n)
    (step && front_res.status_code == mmbcs_pkg::StPassive) |-> !front_res.ad_enable)
    else $error("AD driven with passive status");

  a_read_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !front_res.done) |-> (front_res.read_value == 16'h0000))
    else $error("read data shown without done");

  a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && front_res.done) |=> !(step && front_res.done))
    else $error("two transfer ends in a row");

endmodule

/* design/mmbcs_front.sv */
module mmbcs_front #(
  parameter int ADDRESS_WIDTH = mmbcs_pkg::AddrDefW
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                start_req,
  input  logic [1:0]          operation,
  input  logic                word,
  input  logic [19:0]         address,
  input  logic [15:0]         write_data,
  input  logic                ready_req,
  input  logic [7:0]          bus_data_in,
  output mmbcs_pkg::result_t  res
);

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhT1   = 3'd1;
  localparam logic [2:0] PhT2   = 3'd2;
  localparam logic [2:0] PhT3   = 3'd3;
  localparam logic [2:0] PhTw   = 3'd4;
  localparam logic [2:0] PhT4   = 3'd5;

  logic [2:0]               phase_r, phase_nxt;
  logic [1:0]               op_r, op_nxt;
  logic                     word_r, word_nxt;
  logic                     second_r, second_nxt;
  logic [ADDRESS_WIDTH-1:0] addr_r, addr_nxt;
  logic [15:0]              wdata_r, wdata_nxt;
  logic [7:0]               low_r, low_nxt;
  logic [11:0]              upper_r, upper_nxt;
  logic                     drv_r, drv_nxt;

  logic [mmbcs_pkg::AddrExtW-1:0] t1_addr_ext;
  logic [ADDRESS_WIDTH-1:0]       t1_addr;
  logic [1:0]                     t1_op;
  logic                           op_write;
  logic [7:0]                     wbyte;
  mmbcs_pkg::result_t             res_b;

  assign op_write = op_r[0];
  assign wbyte    = second_r ? wdata_r[15:8] : wdata_r[7:0];

  always_comb begin
    phase_nxt  = phase_r;
    op_nxt     = op_r;
    word_nxt   = word_r;
    second_nxt = second_r;
    addr_nxt   = addr_r;
    wdata_nxt  = wdata_r;
    low_nxt    = low_r;
    drv_nxt    = drv_r;
    t1_addr    = addr_r;
    t1_op      = op_r;
    res_b      = '0;
    res_b.status_code = mmbcs_pkg::StPassive;
    unique case (phase_r)
      PhT2: begin
        res_b.busy        = 1'b1;
        res_b.status_code = mmbcs_pkg::op_status(op_r);
        drv_nxt           = op_write;
        if (op_write) begin
          res_b.ad_value  = wbyte;
          res_b.ad_enable = 1'b1;
        end
        phase_nxt = PhT3;
      end
      PhT3, PhTw: begin
        res_b.busy        = 1'b1;
        res_b.status_code = mmbcs_pkg::op_status(op_r);
        if (drv_r) begin
          res_b.ad_value  = wbyte;
          res_b.ad_enable = 1'b1;
        end
        phase_nxt = ready_req ? PhT4 : PhTw;
      end
      PhT4: begin
        res_b.busy = 1'b1;
        drv_nxt    = 1'b0;
        if (word_r && !second_r) begin
          low_nxt    = bus_data_in;
          second_nxt = 1'b1;
          addr_nxt   = addr_r + ADDRESS_WIDTH'(1);
          phase_nxt  = PhT1;
        end else begin
          res_b.done = 1'b1;
          phase_nxt  = PhIdle;
          if (!op_write) begin
            res_b.read_value = second_r ? {bus_data_in, low_r} : {8'h00, bus_data_in};
          end
        end
      end
      PhT1: begin
        res_b.busy = 1'b1;
      end
      default: begin
        phase_nxt = PhIdle;
        if (start_req) begin
          op_nxt     = operation;
          wdata_nxt  = write_data;
          second_nxt = 1'b0;
          low_nxt    = 8'h00;
          t1_op      = operation;
          if (operation[1]) begin
            word_nxt = 1'b0;
            t1_addr  = ADDRESS_WIDTH'(address[15:0]);
          end else begin
            word_nxt = word;
            t1_addr  = ADDRESS_WIDTH'(address);
          end
          addr_nxt   = t1_addr;
          res_b.busy = 1'b1;
        end else begin
          drv_nxt = 1'b0;
        end
      end
    endcase
  end

  assign t1_addr_ext = mmbcs_pkg::AddrExtW'(t1_addr);

  logic enter_t1;
  assign enter_t1 = (phase_r == PhT1) ||
                    (phase_r != PhT2 && phase_r != PhT3 && phase_r != PhTw &&
                     phase_r != PhT4 && start_req);

  logic [2:0]  phase_fin;
  logic        drv_fin;
  logic [7:0]  adv_fin;
  logic        aden_fin;
  logic [2:0]  st_fin;

  always_comb begin
    phase_fin = phase_nxt;
    drv_fin   = drv_nxt;
    upper_nxt = upper_r;
    adv_fin   = res_b.ad_value;
    aden_fin  = res_b.ad_enable;
    st_fin    = res_b.status_code;
    if (enter_t1) begin
      upper_nxt = t1_addr_ext[19:8];
      drv_fin   = 1'b1;
      adv_fin   = t1_addr[7:0];
      aden_fin  = 1'b1;
      st_fin    = mmbcs_pkg::op_status(t1_op);
      phase_fin = PhT2;
    end
  end

  mmbcs_pkg::result_t res_out;
  always_comb begin
    res_out              = res_b;
    res_out.ad_value     = adv_fin;
    res_out.ad_enable    = aden_fin;
    res_out.status_code  = st_fin;
    res_out.high_address = upper_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PhIdle;
      op_r     <= 2'd0;
      word_r   <= 1'b0;
      second_r <= 1'b0;
      addr_r   <= '0;
      wdata_r  <= 16'h0000;
      low_r    <= 8'h00;
      upper_r  <= 12'h000;
      drv_r    <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_fin;
      op_r     <= op_nxt;
      word_r   <= word_nxt;
      second_r <= second_nxt;
      addr_r   <= addr_nxt;
      wdata_r  <= wdata_nxt;
      low_r    <= low_nxt;
      upper_r  <= upper_nxt;
      drv_r    <= drv_fin;
    end
  end

  assign res = res_out;

endmodule

/* design/mmbcs_queue.sv */
module mmbcs_queue #(
  parameter int DEPTH = mmbcs_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mmbcs_pkg::result_t push_data,
  output logic               full,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mmbcs_pkg::result_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mmbcs_pkg::result_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CntW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |=> (count_r != '0))
    else $error("full queue lost its entries");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - CntW'(1)))
    else $error("pop did not lower the count");

endmodule

/* tb/bus_cycle_checker.sv */
`timescale 1ns / 1ps

module bus_cycle_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tlast,
  output int          mismatch_cnt,
  output int          beats_due
);

  typedef enum logic [2:0] {PhIdle, PhT1, PhT2, PhT3, PhTw, PhT4} bus_phase_t;

  typedef struct packed {
    logic [7:0]  ad_value;
    logic        ad_enable;
    logic [11:0] high_address;
    logic [2:0]  status_code;
    logic        done;
    logic [15:0] read_value;
    logic        busy;
  } bus_pins_t;

  localparam logic [2:0] StatusByOp [4] = '{mmbcs_pkg::StMemRd, mmbcs_pkg::StMemWr,
                                            mmbcs_pkg::StIoRd, mmbcs_pkg::StIoWr};

  bus_phase_t                    phase;
  logic [1:0]                    cur_op;
  logic                          two_bytes;
  logic                          odd_byte;
  logic [mmbcs_pkg::AddrDefW-1:0] cyc_addr;
  logic [15:0]                   wr_word;
  logic [7:0]                    lo_read;
  logic [11:0]                   a_hi;
  logic                          ad_driven;

  bus_pins_t             pins_due [$];
  bus_pins_t             want;
  bus_pins_t             got;
  int                    errs = 0;

  function automatic logic op_writes();
    return cur_op == mmbcs_pkg::OpMemWr || cur_op == mmbcs_pkg::OpIoWr;
  endfunction

  function automatic logic [7:0] write_byte();
    return odd_byte ? wr_word[15:8] : wr_word[7:0];
  endfunction

  function automatic void launch_t1(inout bus_pins_t p);
    a_hi        = cyc_addr[19:8];
    ad_driven   = 1'b1;
    p.ad_value  = cyc_addr[7:0];
    p.ad_enable = 1'b1;
    p.status_code = StatusByOp[cur_op];
    phase       = PhT2;
  endfunction

  function automatic bus_pins_t next_bus_pins(input logic [55:0] b);
    logic        start;
    logic [1:0]  op;
    logic        wrd;
    logic [19:0] addr;
    logic [15:0] wdata;
    logic        rdy;
    logic [7:0]  din;
    bus_pins_t   p;
    start = b[0];
    op    = b[2:1];
    wrd   = b[3];
    addr  = b[23:4];
    wdata = b[39:24];
    rdy   = b[40];
    din   = b[48:41];
    p     = '0;
    p.status_code = mmbcs_pkg::StPassive;
    case (phase)
      PhT2: begin
        p.busy = 1'b1;
        p.status_code = StatusByOp[cur_op];
        ad_driven = op_writes();
        if (ad_driven) begin
          p.ad_value  = write_byte();
          p.ad_enable = 1'b1;
        end
        phase = PhT3;
      end
      PhT3, PhTw: begin
        p.busy = 1'b1;
        p.status_code = StatusByOp[cur_op];
        if (ad_driven) begin
          p.ad_value  = write_byte();
          p.ad_enable = 1'b1;
        end
        phase = rdy ? PhT4 : PhTw;
      end
      PhT4: begin
        p.busy = 1'b1;
        ad_driven = 1'b0;
        if (!op_writes())
          p.read_value = odd_byte ? {din, lo_read} : {8'h00, din};
        if (two_bytes && !odd_byte) begin
          lo_read      = din;
          odd_byte     = 1'b1;
          cyc_addr     = cyc_addr + 20'd1;
          phase        = PhT1;
          p.read_value = '0;
        end else begin
          p.done = 1'b1;
          phase  = PhIdle;
          if (op_writes())
            p.read_value = '0;
        end
      end
      PhT1: begin
        p.busy = 1'b1;
        launch_t1(p);
      end
      default: begin
        phase = PhIdle;
        if (start) begin
          cur_op = op;
          if (op == mmbcs_pkg::OpIoRd || op == mmbcs_pkg::OpIoWr) begin
            two_bytes = 1'b0;
            cyc_addr  = {4'h0, addr[15:0]};
          end else begin
            two_bytes = wrd;
            cyc_addr  = addr;
          end
          wr_word  = wdata;
          odd_byte = 1'b0;
          lo_read  = '0;
          p.busy   = 1'b1;
          launch_t1(p);
        end else begin
          ad_driven = 1'b0;
        end
      end
    endcase
    p.high_address = a_hi;
    return p;
  endfunction

  function automatic int field_diff(input string name, input logic [15:0] exp_v,
                                    input logic [15:0] act_v);
    if (exp_v === act_v)
      return 0;
    $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      phase     = PhIdle;
      cur_op    = mmbcs_pkg::OpMemRd;
      two_bytes = 1'b0;
      odd_byte  = 1'b0;
      cyc_addr  = '0;
      wr_word   = '0;
      lo_read   = '0;
      a_hi      = '0;
      ad_driven = 1'b0;
      pins_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        pins_due.push_back(next_bus_pins(in_tdata));
      if (out_tvalid && out_tready) begin
        got.ad_value     = out_tdata[7:0];
        got.ad_enable    = out_tdata[8];
        got.high_address = out_tdata[20:9];
        got.status_code  = out_tdata[23:21];
        got.read_value   = out_tdata[39:24];
        got.busy         = out_tdata[40];
        got.done         = out_tlast;
        if (pins_due.size() == 0) begin
          $display("%0t: expected no beat, actual %h last %b", $time, out_tdata, out_tlast);
          errs++;
        end else begin
          want = pins_due.pop_front();
          errs += field_diff("ad_value", 16'(want.ad_value), 16'(got.ad_value));
          errs += field_diff("ad_enable", 16'(want.ad_enable), 16'(got.ad_enable));
          errs += field_diff("high_address", 16'(want.high_address),
                             16'(got.high_address));
          errs += field_diff("status_code", 16'(want.status_code), 16'(got.status_code));
          errs += field_diff("done", 16'(want.done), 16'(got.done));
          errs += field_diff("read_value", want.read_value, got.read_value);
          errs += field_diff("busy", 16'(want.busy), 16'(got.busy));
        end
      end
    end
    mismatch_cnt <= errs;
    beats_due    <= pins_due.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  int          mismatch_cnt;
  int          beats_due;
  int          cycle_cnt  = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          n_sent     = 0;

  minimum_mode_bus_cycle_sequencer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  bus_cycle_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .mismatch_cnt (mismatch_cnt),
    .beats_due    (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("minimum_mode_bus_cycle_sequencer_top verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    out_tready <= ($urandom_range(0, 99) >= stall_pct);

  function automatic logic [55:0] beat_of(input logic s, input logic [1:0] op,
                                          input logic w, input logic [19:0] a,
                                          input logic [15:0] d, input logic r,
                                          input logic [7:0] din);
    return {7'd0, din, r, d, a, w, op, s};
  endfunction

  function automatic logic [55:0] busy_beat(input logic r);
    return beat_of(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), 20'($urandom), 16'($urandom), r,
                   8'($urandom));
  endfunction

  function automatic logic [19:0] pick_addr();
    case ($urandom_range(0, 7))
      0:       return 20'hFFFFF;
      1:       return 20'h00000;
      2:       return 20'h0FFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [55:0] d);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct)
      gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic run_transfer(input logic [1:0] op, input logic w, input logic [19:0] a,
                              input logic [15:0] d, input int wmin, input int wmax);
    int n_bytes;
    int n_wait;
    n_bytes = (w && (op == mmbcs_pkg::OpMemRd || op == mmbcs_pkg::OpMemWr)) ? 2 : 1;
    send_beat(beat_of(1'b1, op, w, a, d, 1'($urandom_range(0, 1)), 8'($urandom)));
    for (int k = 0; k < n_bytes; k++) begin
      if (k > 0)
        send_beat(busy_beat(1'($urandom_range(0, 1))));
      send_beat(busy_beat(1'($urandom_range(0, 1))));
      n_wait = $urandom_range(wmin, wmax);
      repeat (n_wait) send_beat(busy_beat(1'b0));
      send_beat(busy_beat(1'b1));
      send_beat(busy_beat(1'($urandom_range(0, 1))));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int n_items, input int idle_p, input int stall_p);
    int stop_at;
    int wmax;
    stop_at   = n_sent + n_items;
    idle_pct  = idle_p;
    stall_pct = stall_p;
    while (n_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        wmax = ($urandom_range(0, 9) == 0) ? 12 : 3;
        run_transfer(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_addr(),
                     16'($urandom), 0, wmax);
      end else begin
        repeat ($urandom_range(1, 6)) send_beat(busy_beat(1'($urandom_range(0, 1))));
        // settle back to idle: a word transfer ends within eight ready beats
        repeat (8)
          send_beat(beat_of(1'b0, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            20'($urandom), 16'($urandom), 1'b1, 8'($urandom)));
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(beat_of(1'b0, mmbcs_pkg::OpMemRd, 1'b0, 20'h00000, 16'h0000, 1'b1, 8'h00));
    run_transfer(mmbcs_pkg::OpMemRd, 1'b1, 20'hFFFFF, 16'h0000, 1, 1);
    run_transfer(mmbcs_pkg::OpMemWr, 1'b1, 20'h00000, 16'hFFFF, 0, 0);
    run_transfer(mmbcs_pkg::OpIoRd, 1'b1, 20'hFFFFF, 16'h0000, 0, 0);
    run_transfer(mmbcs_pkg::OpIoWr, 1'b1, 20'hFFFFF, 16'hFFFF, 0, 0);
    drain();

    random_phase(260, 0, 0);
    random_phase(260, 65, 0);
    random_phase(260, 0, 65);
    random_phase(290, 25, 25);

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && beats_due == 0)
      $display("minimum_mode_bus_cycle_sequencer_top verification clean");
    else
      $display("minimum_mode_bus_cycle_sequencer_top verification failed");
    $finish;
  end

endmodule
